// File: rtl/char_lcd_nibble_write_sequencer_unit_defines.svh
// assertion helpers, clocked on clock and disabled in reset
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_UNIT_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication
`define LCDNWS_ASSERT_IMPL(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("lcd sequencer check failed");

// next-cycle implication
`define LCDNWS_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("lcd sequencer check failed");

`endif

// File: rtl/lcdnws_pkg.sv
package lcdnws_pkg;

   typedef enum logic [1:0] {
      REQ_CMD   = 2'd0,
      REQ_DATA  = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_INIT  = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      CSR_ENABLE   = 2'd0,
      CSR_SETTLE   = 2'd1,
      CSR_CLEAR    = 2'd2,
      CSR_POWER_UP = 2'd3
   } csr_index_type;

   typedef enum logic {
      JOB_BYTE = 1'b0,
      JOB_INIT = 1'b1
   } job_kind_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_RUN  = 1'b1
   } back_state_type;

   localparam logic [7:0] CMD_WAKE       = 8'h30;
   localparam logic [7:0] CMD_FOUR_BIT   = 8'h20;
   localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
   localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
   localparam logic [7:0] CMD_CLEAR      = 8'h01;
   localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
   localparam logic [7:0] HI_MASK        = 8'hF0;

   localparam int unsigned HOLD_W  = 20;
   localparam int unsigned STEP_W  = 5;
   localparam logic [STEP_W-1:0] BYTE_LAST_STEP  = 5'd3;
   localparam logic [STEP_W-1:0] PULSE_LAST_STEP = 5'd8;
   localparam logic [STEP_W-1:0] INIT_LAST_STEP  = 5'd24;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [3:0]        bus_nibble;
      logic              reg_select;
      logic              enable_level;
      logic [HOLD_W-1:0] hold_ticks;
      logic              last_state;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0]  enable_ticks;
      logic [15:0] settle_ticks;
      logic [15:0] clear_ticks;
      logic [19:0] power_up_ticks;
   } cfg_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   byte_val;
      logic         rs;
      logic         clear_wait;
   } job_type;

   // command bytes sent after the wake-up pulses
   function automatic logic [7:0] init_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = CMD_FUNC_SET;
         2'd1:    b = CMD_DISPLAY_ON;
         2'd2:    b = CMD_CLEAR;
         default: b = CMD_ENTRY_MODE;
      endcase
      return b;
   endfunction

endpackage

// File: rtl/char_lcd_nibble_write_sequencer_unit.sv
// first pin state of a request taken into an empty unit: queue entry, back-end job register, then output register
// throughput: one pin state per cycle while rsp_stall is low; 4 for a byte or clear, 25 for init, idle between jobs
// the back-end step counter sets the rate; the queue lets requests pile up meanwhile
// reset: synchronous, active high; empties the queue and output, reloads register defaults
module char_lcd_nibble_write_sequencer_unit
   import lcdnws_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
)
(
   input  logic          clock,
   input  logic          reset,
   // request channel
   input  logic          req_valid,
   output logic          req_stall,
   input  req_item_type  req_item,
   // pin state channel
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_item_type  rsp_item,
   // register writes
   input  logic          csr_write_enable,
   input  logic [1:0]    csr_index,
   input  logic [19:0]   csr_write_data
);

   // timing registers with their power-on values
   cfg_type cfg_ff, cfg_in;

   logic    queue_full;
   logic    queue_empty;
   logic    push;
   logic    pop;
   job_type push_job;
   job_type pop_job;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_ENABLE:   cfg_in.enable_ticks   = csr_write_data[7:0];
            CSR_SETTLE:   cfg_in.settle_ticks   = csr_write_data[15:0];
            CSR_CLEAR:    cfg_in.clear_ticks    = csr_write_data[15:0];
            CSR_POWER_UP: cfg_in.power_up_ticks = csr_write_data;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable_ticks   <= 8'd1;
         cfg_ff.settle_ticks   <= 16'd250;
         cfg_ff.clear_ticks    <= 16'd5000;
         cfg_ff.power_up_ticks <= 20'd200000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: decode the request kind, push a job
   lcdnws_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   // short job queue between the two halves
   lcdnws_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   // back end: walk the pin states of one job, registered output
   lcdnws_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .queue_job   (pop_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item)
   );

endmodule

// File: rtl/lcdnws_front.sv
module lcdnws_front
   import lcdnws_pkg::*;
(
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   input  logic         queue_full,
   output logic         push,
   output job_type      push_job
);

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // classify request into a job for the back end
   always_comb begin
      push_job.kind       = JOB_BYTE;
      push_job.byte_val   = req_item.data_byte;
      push_job.rs         = 1'b0;
      push_job.clear_wait = 1'b0;
      case (req_code_type'(req_item.req_type))
         REQ_CMD: begin
            push_job.rs = 1'b0;
         end
         REQ_DATA: begin
            push_job.rs = 1'b1;
         end
         REQ_CLEAR: begin
            push_job.byte_val   = CMD_CLEAR;
            push_job.clear_wait = 1'b1;
         end
         REQ_INIT: begin
            push_job.kind = JOB_INIT;
         end
         default: begin
            push_job.kind = JOB_BYTE;
         end
      endcase
   end

endmodule

// File: rtl/lcdnws_queue.sv
module lcdnws_queue
   import lcdnws_pkg::*;
#(
   parameter int unsigned DEPTH = 2
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type pop_job,
   output logic    full,
   output logic    empty
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/lcdnws_back.sv
module lcdnws_back
   import lcdnws_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         queue_empty,
   input  job_type      queue_job,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   `include "char_lcd_nibble_write_sequencer_unit_defines.svh"

   back_state_type    state_ff, state_in;
   job_type           job_ff, job_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;

   logic              load_out;
   rsp_item_type      pin;
   logic [STEP_W-1:0] rel;
   logic [1:0]        sub;
   logic [7:0]        cur_byte;
   logic              cur_clear;
   logic [3:0]        pulse_idx;
   logic [16:0]       clear_sum;

   assign clear_sum = {1'b0, cfg.settle_ticks} + {1'b0, cfg.clear_ticks};

   // pin state for the current job and step
   always_comb begin
      rel       = step_ff - 5'd9;
      pulse_idx = 4'(step_ff - 5'd1);
      sub       = (job_ff.kind == JOB_INIT) ? rel[1:0] : step_ff[1:0];
      cur_byte  = (job_ff.kind == JOB_INIT) ? init_byte(rel[3:2]) : job_ff.byte_val;
      cur_clear = (job_ff.kind == JOB_INIT) ? (rel[3:2] == 2'd2) : job_ff.clear_wait;

      // byte write: hi E1, hi E0, lo E1, lo E0 with tail wait
      pin.bus_nibble   = sub[1] ? cur_byte[3:0] : 4'((cur_byte & HI_MASK) >> 4);
      pin.reg_select   = (job_ff.kind == JOB_INIT) ? 1'b0 : job_ff.rs;
      pin.enable_level = !sub[0];
      case (sub)
         2'd0, 2'd2: pin.hold_ticks = HOLD_W'(cfg.enable_ticks);
         2'd1:       pin.hold_ticks = '0;
         default: begin
            pin.hold_ticks = cur_clear ? HOLD_W'(clear_sum) : HOLD_W'(cfg.settle_ticks);
         end
      endcase

      if (job_ff.kind == JOB_INIT) begin
         if (step_ff == '0) begin
            pin.bus_nibble   = '0;
            pin.enable_level = 1'b0;
            pin.hold_ticks   = cfg.power_up_ticks;
         end else if (step_ff <= PULSE_LAST_STEP) begin
            // wake pulses then the 4-bit switch pulse
            pin.bus_nibble   = (pulse_idx < 4'd6) ? 4'(CMD_WAKE >> 4) : 4'(CMD_FOUR_BIT >> 4);
            pin.enable_level = !pulse_idx[0];
            pin.hold_ticks   = pulse_idx[0] ? HOLD_W'(cfg.settle_ticks)
                                            : HOLD_W'(cfg.enable_ticks);
         end
         pin.last_state = (step_ff == INIT_LAST_STEP);
      end else begin
         pin.last_state = (step_ff == BYTE_LAST_STEP);
      end
   end

   assign load_out = (state_ff == BK_RUN) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      step_in      = step_ff;
      pop          = 1'b0;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               job_in   = queue_job;
               step_in  = '0;
               state_in = BK_RUN;
            end
         end
         BK_RUN: begin
            if (load_out) begin
               rsp_item_in  = pin;
               rsp_valid_in = 1'b1;
               if (pin.last_state) begin
                  state_in = BK_IDLE;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `LCDNWS_ASSERT_IMPL(a_pop_only_idle, pop, state_ff == BK_IDLE)
   `LCDNWS_ASSERT_IMPL(a_byte_step_range, state_ff == BK_RUN && job_ff.kind == JOB_BYTE,
                       step_ff <= BYTE_LAST_STEP)
   `LCDNWS_ASSERT_IMPL(a_init_step_range, state_ff == BK_RUN, step_ff <= INIT_LAST_STEP)
   `LCDNWS_ASSERT_NEXT(a_last_ends_job, load_out && pin.last_state, state_ff == BK_IDLE)

endmodule
